>>> design/dtws_pkg.sv
// ----------------------------------------------------------------------------
// Dual-tone synthesiser package
// Shared widths, constants, the word types passed between the front end, the
// queue and the back end, and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package dtws_pkg;

	// Wave table geometry and phase format (10.16 fixed point).
	localparam int TABLE_LEN = 1000;
	localparam int IDX_W     = $clog2(TABLE_LEN);
	localparam int FRAC_W    = 16;
	localparam int PHASE_W   = IDX_W + FRAC_W;

	// Field widths of the ports.
	localparam int STEP_W      = 26;
	localparam int VOLUME_W    = 12;
	localparam int PWM_W       = 12;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = STEP_W;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_A = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_B = CFG_INDEX_W'(1);

	// One full turn of the phase, and the width used to clamp a written step.
	localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W+1)'(64'(TABLE_LEN) << FRAC_W);
	localparam int CLAMP_W = (STEP_W > PHASE_W + 1) ? STEP_W : PHASE_W + 1;

	// Quarter-wave table: magnitudes only repeat at this granularity.
	localparam int QSHIFT  = (TABLE_LEN % 4 == 0) ? 2 : ((TABLE_LEN % 2 == 0) ? 1 : 0);
	localparam int QSTEP   = 1 << QSHIFT;
	localparam int QDEPTH  = TABLE_LEN / QSTEP + 1;
	localparam int QIDX_W  = $clog2(QDEPTH);

	// Datapath widths and output scaling.
	localparam int MAG_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int MIX_W      = SAMPLE_W + 1;
	localparam int PROD_W     = MIX_W + VOLUME_W + 1;
	localparam int OUT_SHIFT  = 18;
	localparam int PWM_OFFSET = 1200;

	// Queue between front and back end.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// One queued tick: both table indexes and the volume that goes with them.
	typedef struct packed {
		logic [IDX_W-1:0]    idx_a;
		logic [IDX_W-1:0]    idx_b;
		logic [VOLUME_W-1:0] volume;
	} tick_t;

	// A table index folded onto the first quadrant.
	typedef struct packed {
		logic [QIDX_W-1:0] qidx;
		logic              neg;
	} fold_t;

	typedef logic [MAG_W-1:0] quarter_rom_t [QDEPTH];

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// Q15 magnitude of the sine at angle rem/TABLE_LEN of a quarter turn,
	// truncated toward zero, from a Q30 Taylor series.
	function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned rem);
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned s;
		longint          sum;
		if (rem == 0) begin
			return '0;
		end
		if (rem == TABLE_LEN) begin
			return MAG_W'(32767);
		end
		theta = (PI_HALF_Q30 * 64'(rem)) / TABLE_LEN;
		x2    = (theta * theta) >> 30;
		term  = theta;
		sum   = longint'(theta);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		s = longint'(unsigned'(sum));
		return MAG_W'((64'd32767 * s) >> 30);
	endfunction

	function automatic quarter_rom_t build_quarter_rom();
		quarter_rom_t rom;
		for (int j = 0; j < QDEPTH; j++) begin
			rom[j] = quarter_mag(j * QSTEP);
		end
		return rom;
	endfunction

	localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage

>>> design/dtws_front.sv
// ----------------------------------------------------------------------------
// Dual-tone synthesiser front end
// Holds the phase steps and accumulators, advances both phases on each tick
// accepted with no register write, and queues the table indexes and volume.
// ----------------------------------------------------------------------------
module dtws_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [dtws_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dtws_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               tick_valid,
	output logic                               tick_ready,
	input  logic [dtws_pkg::VOLUME_W-1:0]      volume,
	input  logic                               fifo_full,
	output logic                               fifo_push,
	output dtws_pkg::tick_t                    fifo_data
);
	import dtws_pkg::*;

	logic [PHASE_W-1:0] step_a_q, step_b_q;
	logic [PHASE_W-1:0] phase_a_q, phase_b_q;
	logic [PHASE_W-1:0] next_a, next_b;
	logic [PHASE_W-1:0] step_clamped;
	logic [CLAMP_W-1:0] data_wide;

	function automatic logic [PHASE_W-1:0] advance(input logic [PHASE_W-1:0] phase,
		input logic [PHASE_W-1:0] step);
		logic [PHASE_W:0] sum;
		sum = {1'b0, phase} + {1'b0, step};
		if (sum >= PHASE_LIMIT) begin
			sum = sum - PHASE_LIMIT;
		end
		return sum[PHASE_W-1:0];
	endfunction

	// A step of a full turn or more is held just below it.
	always_comb begin
		data_wide = CLAMP_W'(cfg_data);
		if (data_wide >= CLAMP_W'(PHASE_LIMIT)) begin
			step_clamped = PHASE_W'(PHASE_LIMIT - 1'b1);
		end else begin
			step_clamped = PHASE_W'(data_wide);
		end
	end

	assign next_a     = advance(phase_a_q, step_a_q);
	assign next_b     = advance(phase_b_q, step_b_q);
	assign tick_ready = !fifo_full;
	assign fifo_push  = tick_valid && !fifo_full;

	assign fifo_data.idx_a  = next_a[PHASE_W-1:FRAC_W];
	assign fifo_data.idx_b  = next_b[PHASE_W-1:FRAC_W];
	assign fifo_data.volume = volume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a_q  <= '0;
			step_b_q  <= '0;
			phase_a_q <= '0;
			phase_b_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PHASE_STEP_A: begin
					step_a_q <= step_clamped;
					if (step_clamped == '0) begin
						phase_a_q <= '0;
					end
				end
				REG_PHASE_STEP_B: begin
					step_b_q <= step_clamped;
					if (step_clamped == '0) begin
						phase_b_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end else if (fifo_push) begin
			phase_a_q <= next_a;
			phase_b_q <= next_b;
		end
	end

endmodule

>>> design/dtws_fifo.sv
// ----------------------------------------------------------------------------
// Dual-tone synthesiser tick queue
// Short register queue that lets the front and back ends stall on their own.
// ----------------------------------------------------------------------------
module dtws_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dtws_pkg::tick_t push_data,
	output logic            full,
	input  logic            pop,
	output dtws_pkg::tick_t pop_data,
	output logic            empty
);
	import dtws_pkg::*;

	tick_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full     = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/dtws_back.sv
// ----------------------------------------------------------------------------
// Dual-tone synthesiser back end
// Folds the indexes onto a quarter wave, looks up both samples, mixes and
// scales them by the volume and holds the compare value in an output register.
// ----------------------------------------------------------------------------
module dtws_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fifo_empty,
	input  dtws_pkg::tick_t               fifo_data,
	output logic                          fifo_pop,
	output logic                          sample_valid,
	input  logic                          sample_ready,
	output logic [dtws_pkg::PWM_W-1:0]    pwm_compare
);
	import dtws_pkg::*;

	localparam logic [IDX_W+1:0] QUAD_1 = (IDX_W+2)'(TABLE_LEN);
	localparam logic [IDX_W+1:0] QUAD_2 = (IDX_W+2)'(2 * TABLE_LEN);
	localparam logic [IDX_W+1:0] QUAD_3 = (IDX_W+2)'(3 * TABLE_LEN);

	logic                       en;
	logic                       valid_s1, valid_s2, valid_s3, valid_q;
	fold_t                      fold_a_s1, fold_b_s1;
	logic [VOLUME_W-1:0]        vol_s1, vol_s2;
	logic signed [SAMPLE_W-1:0] samp_a_s2, samp_b_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic [PWM_W-1:0]           pwm_q;
	logic signed [MIX_W-1:0]    mix;
	logic signed [SAMPLE_W-1:0] samp_a, samp_b;

	function automatic fold_t fold_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+1:0] x4;
		logic [IDX_W+1:0] rem;
		logic [1:0]       quad;
		fold_t            f;
		x4 = {idx, 2'b00};
		if (x4 >= QUAD_3) begin
			quad = 2'd3;
			rem  = x4 - QUAD_3;
		end else if (x4 >= QUAD_2) begin
			quad = 2'd2;
			rem  = x4 - QUAD_2;
		end else if (x4 >= QUAD_1) begin
			quad = 2'd1;
			rem  = x4 - QUAD_1;
		end else begin
			quad = 2'd0;
			rem  = x4;
		end
		// Falling quarters run the table backwards.
		if (quad[0]) begin
			rem = QUAD_1 - rem;
		end
		f.qidx = QIDX_W'(rem >> QSHIFT);
		f.neg  = quad[1];
		return f;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] lookup(input fold_t f);
		logic signed [SAMPLE_W-1:0] mag;
		mag = $signed({1'b0, QUARTER_ROM[f.qidx]});
		return f.neg ? -mag : mag;
	endfunction

	// The whole pipe moves whenever the output register is free or being taken.
	assign en           = !valid_q || sample_ready;
	assign fifo_pop     = en && !fifo_empty;
	assign sample_valid = valid_q;
	assign pwm_compare  = pwm_q;

	assign samp_a = lookup(fold_a_s1);
	assign samp_b = lookup(fold_b_s1);
	assign mix    = MIX_W'(samp_a_s2) + MIX_W'(samp_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= !fifo_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_a_s1 <= fold_index(fifo_data.idx_a);
			fold_b_s1 <= fold_index(fifo_data.idx_b);
			vol_s1    <= fifo_data.volume;
			samp_a_s2 <= samp_a;
			samp_b_s2 <= samp_b;
			vol_s2    <= vol_s1;
			prod_s3   <= PROD_W'(mix) * PROD_W'($signed({1'b0, vol_s2}));
			pwm_q     <= PWM_W'(prod_s3 >>> OUT_SHIFT) + PWM_W'(PWM_OFFSET);
		end
	end

endmodule

>>> design/dual_tone_wavetable_synth_unit.sv
// ----------------------------------------------------------------------------
// Dual-tone wavetable synthesiser
// Two 10.16 phase accumulators drive a shared sine table; the mixed samples
// are scaled by the volume and offset to give a PWM compare value.
// ----------------------------------------------------------------------------

// Each word accepted on the tick channel is one sample tick carrying the
// current volume, and it produces exactly one compare value on the sample
// channel, in order. The block takes one word per cycle for as long as the
// sample side keeps up; the rate is set by the single multiplier stage of
// the back end, which like every other stage handles one word a cycle. A
// compare value passes through the four-word queue, then the quadrant fold,
// the table lookup, the mix-and-multiply and the output register. The queue
// lets ticks keep arriving for four more words while the sample side stalls.
// The phase steps are to be written through the configuration port only
// while no tick is in flight; the block itself does not enforce this. A step
// of one full turn or more is held just below a turn, and writing a zero
// step also clears that tone's phase. There is no clearing pass after reset:
// the sine table is a constant quarter-wave table.
module dual_tone_wavetable_synth_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [dtws_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dtws_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             tick_valid,
	output logic                             tick_ready,
	input  logic [dtws_pkg::VOLUME_W-1:0]    volume,
	output logic                             sample_valid,
	input  logic                             sample_ready,
	output logic [dtws_pkg::PWM_W-1:0]       pwm_compare
);
	import dtws_pkg::*;

	// Queue wiring between the front end and the back end.
	tick_t push_data, pop_data;
	logic  push, pop, full, empty;

	// The front end advances the phases and queues the table indexes.
	dtws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.volume     (volume),
		.fifo_full  (full),
		.fifo_push  (push),
		.fifo_data  (push_data)
	);

	dtws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The back end turns queued indexes into scaled compare values.
	dtws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (empty),
		.fifo_data    (pop_data),
		.fifo_pop     (pop),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pwm_compare  (pwm_compare)
	);

endmodule

>>> test/tone_sample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-tone synthesiser sample checker
// Watches the configuration port and both channels of the synthesiser, keeps
// its own copy of the phase steps and phases, predicts each compare value and
// checks every sample word against the oldest prediction.
// ----------------------------------------------------------------------------
module tone_sample_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [dtws_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dtws_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             tick_valid,
	input  logic                             tick_ready,
	input  logic [dtws_pkg::VOLUME_W-1:0]    volume,
	input  logic                             sample_valid,
	input  logic                             sample_ready,
	input  logic [dtws_pkg::PWM_W-1:0]       pwm_compare,
	output int                               failures,
	output int                               outstanding
);
	import dtws_pkg::*;

	localparam longint          TURN        = longint'(TABLE_LEN) << FRAC_W;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          MID_LEVEL   = 1200;
	localparam int              REPORT_MAX  = 10;

	logic signed [15:0]  sine_table [TABLE_LEN];
	longint              tone_a_phase;
	longint              tone_b_phase;
	longint              tone_a_step;
	longint              tone_b_step;
	logic [PWM_W-1:0]    expected_pwm [$];
	logic [PWM_W-1:0]    oldest_pwm;
	longint              written_step;

	// One entry of a full sine cycle in Q15, truncated toward zero. The first
	// quadrant comes from a Q30 Taylor series; the others follow by symmetry.
	function automatic logic signed [15:0] sine_entry(input int unsigned i);
		int unsigned     quarter;
		int unsigned     offs;
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          acc;
		longint          mag;
		quarter = (4 * i) / TABLE_LEN;
		offs    = 4 * i - quarter * TABLE_LEN;
		if (quarter % 2 == 1) begin
			offs = TABLE_LEN - offs;
		end
		if (offs == 0) begin
			mag = 0;
		end else if (offs == TABLE_LEN) begin
			mag = 32767;
		end else begin
			ang    = (HALF_PI_Q30 * 64'(offs)) / 64'(TABLE_LEN);
			ang_sq = (ang * ang) >> 30;
			term   = ang;
			acc    = longint'(ang);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > (longint'(1) << 30)) begin
				acc = longint'(1) << 30;
			end
			mag = (longint'(32767) * acc) >>> 30;
		end
		if (quarter >= 2) begin
			mag = -mag;
		end
		return 16'(mag);
	endfunction

	// Advances both tones by one tick and returns the compare value.
	function automatic logic [PWM_W-1:0] next_compare(input logic [VOLUME_W-1:0] vol);
		longint ia;
		longint ib;
		longint mix;
		tone_a_phase = tone_a_phase + tone_a_step;
		if (tone_a_phase >= TURN) begin
			tone_a_phase = tone_a_phase - TURN;
		end
		tone_b_phase = tone_b_phase + tone_b_step;
		if (tone_b_phase >= TURN) begin
			tone_b_phase = tone_b_phase - TURN;
		end
		ia = tone_a_phase >> FRAC_W;
		ib = tone_b_phase >> FRAC_W;
		if (ia >= TABLE_LEN) begin
			ia = TABLE_LEN - 1;
		end
		if (ib >= TABLE_LEN) begin
			ib = TABLE_LEN - 1;
		end
		mix = (longint'(sine_table[ia]) + longint'(sine_table[ib])) * longint'(vol);
		return PWM_W'((mix >>> 18) + MID_LEVEL);
	endfunction

	initial begin
		for (int i = 0; i < TABLE_LEN; i++) begin
			sine_table[i] = sine_entry(i);
		end
	end

	// A sample word is matched before a tick of the same edge is predicted,
	// since the block cannot answer a tick in the cycle that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_a_phase = 0;
			tone_b_phase = 0;
			tone_a_step  = 0;
			tone_b_step  = 0;
			expected_pwm.delete();
			outstanding  = 0;
			failures     = 0;
		end else begin
			if (cfg_wr_en) begin
				written_step = longint'(cfg_data);
				if (written_step >= TURN) begin
					written_step = TURN - 1;
				end
				case (cfg_index)
					REG_PHASE_STEP_A: begin
						tone_a_step = written_step;
						if (written_step == 0) begin
							tone_a_phase = 0;
						end
					end
					REG_PHASE_STEP_B: begin
						tone_b_step = written_step;
						if (written_step == 0) begin
							tone_b_phase = 0;
						end
					end
					default: begin
					end
				endcase
			end
			if (sample_valid && sample_ready) begin
				if (expected_pwm.size() == 0) begin
					if (failures < REPORT_MAX) begin
						$display("%0t: sample word %0d with no tick outstanding",
							$realtime, pwm_compare);
					end
					failures = failures + 1;
				end else begin
					oldest_pwm = expected_pwm.pop_front();
					if (pwm_compare !== oldest_pwm) begin
						if (failures < REPORT_MAX) begin
							$display("%0t: pwm_compare expected %0d, got %0d",
								$realtime, oldest_pwm, pwm_compare);
						end
						failures = failures + 1;
					end
				end
			end
			if (tick_valid && tick_ready) begin
				expected_pwm.push_back(next_compare(volume));
			end
			outstanding = expected_pwm.size();
		end
	end

endmodule

>>> test/tb_dual_tone_wavetable_synth_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-tone synthesiser testbench
// Drives volume ticks and phase step writes into the synthesiser with random
// idling on both channels; a checker beside the block predicts and compares
// every compare value, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_tone_wavetable_synth_unit;
	import dtws_pkg::*;

	// The limit leaves a wide margin above the slowest correct run.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TICK_TARGET  = 1500;
	localparam int SETTLE_TICKS = 8;

	localparam logic [STEP_W-1:0] STEP_ALL_ONES = '1;
	localparam logic [STEP_W-1:0] STEP_TURN     = STEP_W'(TABLE_LEN * 65536);
	localparam logic [STEP_W-1:0] STEP_BELOW    = STEP_W'(TABLE_LEN * 65536 - 1);
	localparam logic [STEP_W-1:0] STEP_ONE_IDX  = STEP_W'(65536);
	localparam logic [STEP_W-1:0] STEP_QUARTER  = STEP_W'((TABLE_LEN / 4) * 65536);
	localparam logic [STEP_W-1:0] STEP_3QUARTER = STEP_W'((3 * TABLE_LEN / 4) * 65536);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   tick_valid = 1'b0;
	logic                   tick_ready;
	logic [VOLUME_W-1:0]    volume = '0;
	logic                   sample_valid;
	logic                   sample_ready = 1'b0;
	logic [PWM_W-1:0]       pwm_compare;

	int                     failures;
	int                     outstanding;
	int                     cycle_count = 0;
	int                     ticks_sent = 0;
	// When clear, neither side idles: used for one long unbroken stretch.
	logic                   jitter_on = 1'b1;

	always #5 clk = ~clk;

	dual_tone_wavetable_synth_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.volume       (volume),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pwm_compare  (pwm_compare)
	);

	tone_sample_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.volume       (volume),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pwm_compare  (pwm_compare),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The sample side stalls about a fifth of the time while jitter is on.
	always @(posedge clk) begin
		if (jitter_on) begin
			sample_ready <= ($urandom_range(99) >= 20);
		end else begin
			sample_ready <= 1'b1;
		end
	end

	// Offers one tick word and returns at the edge that accepts it. Valid is
	// left high so that the next word can follow without a gap. Handshake
	// inputs are sampled at the falling edge, well clear of the rising edge
	// at which everything is driven.
	task automatic send_tick(input logic [VOLUME_W-1:0] vol);
		if (jitter_on && $urandom_range(99) < 20) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		volume     <= vol;
		@(negedge clk);
		while (!tick_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		ticks_sent = ticks_sent + 1;
	endtask

	// Stops sending and waits until every predicted sample word has come
	// back, then lets the pipeline settle before any register write.
	task automatic wait_drained();
		tick_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_step(input logic [CFG_INDEX_W-1:0] idx, input logic [STEP_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Steps are mostly ordinary pitches, with zero, the all-ones pattern
	// and the value just below a full turn mixed in.
	function automatic logic [STEP_W-1:0] pick_step();
		logic [STEP_W-1:0] value;
		case ($urandom_range(7))
			0: value = '0;
			1: value = STEP_ALL_ONES;
			2: value = STEP_BELOW;
			3: value = STEP_W'($urandom);
			4: value = STEP_W'($urandom_range(1, 1 << 20));
			default: value = STEP_W'($urandom_range(1, TABLE_LEN * 65536 - 1));
		endcase
		return value;
	endfunction

	function automatic logic [VOLUME_W-1:0] pick_volume();
		logic [VOLUME_W-1:0] value;
		case ($urandom_range(9))
			0: value = '0;
			1: value = '1;
			default: value = VOLUME_W'($urandom_range(0, 4095));
		endcase
		return value;
	endfunction

	initial begin
		int phase_len;
		int phase_no;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both steps at reset are zero, so the output sits at mid level
		// whatever the volume.
		send_tick('0);
		send_tick('1);
		send_tick(VOLUME_W'(2048));
		wait_drained();

		// Quarter-turn steps land on the exact table points: the positive peak,
		// zero, the negative peak and zero, giving both output extremes at full
		// volume.
		write_step(REG_PHASE_STEP_A, STEP_QUARTER);
		write_step(REG_PHASE_STEP_B, STEP_QUARTER);
		repeat (4) send_tick('1);
		wait_drained();

		// Tones a quarter and three quarters of a turn per tick cancel out.
		write_step(REG_PHASE_STEP_B, STEP_3QUARTER);
		repeat (2) send_tick('1);
		wait_drained();

		// Steps at and beyond a full turn are held just below it; small
		// volumes with negative sums show the floor of the shift.
		write_step(REG_PHASE_STEP_A, STEP_ALL_ONES);
		write_step(REG_PHASE_STEP_B, STEP_TURN);
		send_tick('1);
		send_tick(VOLUME_W'(1));
		send_tick(VOLUME_W'(2));
		wait_drained();

		// A zero step freezes tone A and clears its phase.
		write_step(REG_PHASE_STEP_A, '0);
		write_step(REG_PHASE_STEP_B, STEP_W'(1));
		repeat (2) send_tick('1);
		wait_drained();

		write_step(REG_PHASE_STEP_A, STEP_ONE_IDX);
		write_step(REG_PHASE_STEP_B, STEP_BELOW);
		repeat (4) send_tick(pick_volume());
		wait_drained();

		// Random phases: new steps, then a run of ticks. One phase runs with
		// no idling on either side; each phase ends by draining completely.
		ticks_sent = 0;
		phase_no   = 0;
		while (ticks_sent < TICK_TARGET) begin
			jitter_on = (phase_no != 3);
			if ($urandom_range(3) != 0) begin
				write_step(REG_PHASE_STEP_A, pick_step());
			end
			if ($urandom_range(3) != 0) begin
				write_step(REG_PHASE_STEP_B, pick_step());
			end
			phase_len = $urandom_range(60, 180);
			repeat (phase_len) send_tick(pick_volume());
			wait_drained();
			phase_no = phase_no + 1;
		end
		jitter_on = 1'b1;

		repeat (20) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
